// ===== rtl/core/asgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Annular sector gradient shader package
// Shared types, widths, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package asgs_pkg;

    localparam int PIXEL_W           = 12;
    localparam int CHAN_W            = 8;
    localparam int CHANNELS          = 4;
    localparam int RADIUS_W          = 16;
    localparam int ANGLE_W           = 15;
    localparam int ANG_W             = 16;
    localparam int COLOR_W           = 32;
    localparam int DIST_EXTRA        = 7;
    localparam int DIV_STEPS         = CHAN_W;
    localparam int ATAN_LEN          = 24;
    localparam int Z_W               = 28;
    localparam int ROUND_SHIFT       = 12;
    localparam int CORDIC_PRESCALE   = 8;

    localparam int DEF_COORD_BITS    = 12;
    localparam int DEF_FRAC_BITS     = 4;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_COLOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COLOR  = 3'd7;

    localparam logic [RADIUS_W-1:0] OUTER_RADIUS_RST = 16'd16;
    localparam logic [ANGLE_W-1:0]  WRAP_ANGLE       = 15'd25723;

    localparam logic signed [Z_W-1:0] ANGLE_PI   = Z_W'(52707179);
    localparam logic [Z_W-1:0]        ROUND_HALF = Z_W'(2048);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic              covered;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_result;

    // Arctangent of 2^-i in units of 2^-24 radian, rounded to nearest.
    function automatic logic [Z_W-1:0] atan_entry(input int unsigned idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(13176795);
            1:       v = Z_W'(7778716);
            2:       v = Z_W'(4110060);
            3:       v = Z_W'(2086331);
            4:       v = Z_W'(1047214);
            5:       v = Z_W'(524117);
            6:       v = Z_W'(262123);
            7:       v = Z_W'(131069);
            8:       v = Z_W'(65536);
            9:       v = Z_W'(32768);
            10:      v = Z_W'(16384);
            11:      v = Z_W'(8192);
            12:      v = Z_W'(4096);
            13:      v = Z_W'(2048);
            14:      v = Z_W'(1024);
            15:      v = Z_W'(512);
            16:      v = Z_W'(256);
            17:      v = Z_W'(128);
            18:      v = Z_W'(64);
            19:      v = Z_W'(32);
            20:      v = Z_W'(16);
            21:      v = Z_W'(8);
            22:      v = Z_W'(4);
            23:      v = Z_W'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/asgs_isqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring square root, one root bit per register stage, with a sideband
// word that travels alongside.
// ----------------------------------------------------------------------------
module asgs_isqrt #(
    parameter int RW  = 24,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_radicand,
    input  logic [SBW-1:0]  i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_side
);

    logic [2*RW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [SBW-1:0]  r_side [RW];
    logic            r_vld  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int B = RW - 1 - k;
        logic [2*RW-1:0] rem_in;
        logic [2*RW-1:0] trial;
        logic [RW-1:0]   root_in;
        logic [SBW-1:0]  side_in;
        logic            vld_in;

        if (k == 0) begin : g_first
            assign rem_in  = i_radicand;
            assign root_in = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // The root only has bits above B set, so these two terms never overlap.
        assign trial = ((2*RW)'(root_in) << (B + 1)) | ((2*RW)'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= side_in;
            if (rem_in >= trial) begin
                r_rem[k]  <= rem_in - trial;
                r_root[k] <= root_in | (RW'(1) << B);
            end else begin
                r_rem[k]  <= rem_in;
                r_root[k] <= root_in;
            end
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ===== rtl/core/asgs_cordic.sv =====
// ----------------------------------------------------------------------------
// Pipelined CORDIC angle unit
// Vectoring CORDIC, one micro-rotation per stage, giving atan2 in radians
// with 12 fraction bits, wrapped into the positive range.
// ----------------------------------------------------------------------------
module asgs_cordic #(
    parameter int DXW    = 17,
    parameter int STAGES = 16,
    parameter int SBW    = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic signed [DXW-1:0]   i_dx,
    input  logic signed [DXW-1:0]   i_dy,
    input  logic [SBW-1:0]          i_side,
    output logic                    o_valid,
    output logic [asgs_pkg::ANG_W-1:0] o_angle,
    output logic [SBW-1:0]          o_side
);

    import asgs_pkg::*;

    localparam int CW = DXW + CORDIC_PRESCALE + 2;

    logic signed [CW-1:0]  r_x    [STAGES+1];
    logic signed [CW-1:0]  r_y    [STAGES+1];
    logic signed [Z_W-1:0] r_z    [STAGES+1];
    logic [SBW-1:0]        r_side [STAGES+1];
    logic                  r_vld  [STAGES+1];

    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;

    assign x0 = CW'(i_dx) <<< CORDIC_PRESCALE;
    assign y0 = CW'(i_dy) <<< CORDIC_PRESCALE;

    // A vector in the left half plane is first turned by half a turn.
    always_ff @(posedge i_clk) begin
        r_side[0] <= i_side;
        if (x0 < 0) begin
            r_x[0] <= -x0;
            r_y[0] <= -y0;
            r_z[0] <= (y0 >= 0) ? ANGLE_PI : -ANGLE_PI;
        end else begin
            r_x[0] <= x0;
            r_y[0] <= y0;
            r_z[0] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [CW-1:0]  xs;
        logic signed [CW-1:0]  ys;
        logic signed [Z_W-1:0] at;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign at = $signed(atan_entry(i));

        always_ff @(posedge i_clk) begin
            r_side[i+1] <= r_side[i];
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + at;
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - at;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end
    end

    logic signed [Z_W-1:0] z_fin;
    logic [Z_W-1:0]        z_mag;
    logic [Z_W-1:0]        z_q;
    logic [ANG_W-1:0]      n_angle;

    assign z_fin = r_z[STAGES];
    assign z_mag = (z_fin < 0) ? Z_W'(-z_fin) : Z_W'(z_fin);
    assign z_q   = (z_mag + ROUND_HALF) >> ROUND_SHIFT;

    // Rounding is to nearest with ties away from zero; a negative angle that
    // rounds to zero stays zero rather than wrapping.
    always_comb begin
        if ((z_fin < 0) && (z_q != '0)) begin
            n_angle = ANG_W'(WRAP_ANGLE) - ANG_W'(z_q);
        end else begin
            n_angle = ANG_W'(z_q);
        end
    end

    logic                r_ovld;
    logic [ANG_W-1:0]    r_angle;
    logic [SBW-1:0]      r_oside;

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
        r_oside <= r_side[STAGES];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= r_vld[STAGES];
        end
    end

    assign o_valid = r_ovld;
    assign o_angle = r_angle;
    assign o_side  = r_oside;

endmodule

// ===== rtl/core/annular_sector_gradient_shader_unit.sv =====
// ----------------------------------------------------------------------------
// Annular sector gradient shader unit
// Root width RW follows from COORD_BITS and FRAC_BITS; the default parameters
// give RW = 24 and 16 CORDIC stages.
// Throughput: one pixel word per clock outside reset, set by the fully
// pipelined square root, CORDIC and channel dividers. Results cannot be
// stalled. Reset is synchronous and active low; busy is high while reset
// is applied, and the registers return to their documented reset values.
// ----------------------------------------------------------------------------
module annular_sector_gradient_shader_unit #(
    parameter int COORD_BITS    = asgs_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS     = asgs_pkg::DEF_FRAC_BITS,
    parameter int CORDIC_STAGES = asgs_pkg::DEF_CORDIC_STAGES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  asgs_pkg::t_pixel                  i_pixel,
    output logic                              o_done,
    output asgs_pkg::t_result                 o_result,
    input  logic                              i_cfg_wr_en,
    input  logic [asgs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [asgs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    import asgs_pkg::*;

    localparam int PXW     = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam int MAG_W   = (PXW + FRAC_BITS > RADIUS_W) ? PXW + FRAC_BITS : RADIUS_W;
    localparam int DXW     = MAG_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int DSQ_W   = 2 * MAG_W + 1;
    localparam int RW      = MAG_W + 8;
    localparam int SPAN_W  = RADIUS_W + DIST_EXTRA;
    localparam int NUM_W   = RW + CHAN_W;
    localparam int PR_W    = FRAC_BITS + DIST_EXTRA + 1;
    localparam int AP_W    = CHAN_W + PR_W;
    localparam int STG     = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int LATENCY = RW + STG + 17;
    localparam logic [RW-1:0] ONE_RW = RW'(1) << (FRAC_BITS + DIST_EXTRA);

    // ------------------------------------------------------------------
    // Configuration registers and values derived from them
    // ------------------------------------------------------------------
    logic [RADIUS_W-1:0] r_center_x;
    logic [RADIUS_W-1:0] r_center_y;
    logic [RADIUS_W-1:0] r_inner;
    logic [RADIUS_W-1:0] r_outer;
    logic [ANGLE_W-1:0]  r_start_ang;
    logic [ANGLE_W-1:0]  r_end_ang;
    logic [COLOR_W-1:0]  r_inner_color;
    logic [COLOR_W-1:0]  r_outer_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= '0;
            r_center_y    <= '0;
            r_inner       <= '0;
            r_outer       <= OUTER_RADIUS_RST;
            r_start_ang   <= '0;
            r_end_ang     <= WRAP_ANGLE;
            r_inner_color <= '0;
            r_outer_color <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_CENTER_X:     r_center_x    <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_CENTER_Y:     r_center_y    <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_INNER_RADIUS: r_inner       <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_OUTER_RADIUS: r_outer       <= i_cfg_wdata[RADIUS_W-1:0];
                CFG_START_ANGLE:  r_start_ang   <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_END_ANGLE:    r_end_ang     <= i_cfg_wdata[ANGLE_W-1:0];
                CFG_INNER_COLOR:  r_inner_color <= i_cfg_wdata[COLOR_W-1:0];
                CFG_OUTER_COLOR:  r_outer_color <= i_cfg_wdata[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    logic [2*RADIUS_W-1:0] r_inner_sq;
    logic [2*RADIUS_W-1:0] r_outer_sq;
    logic [SPAN_W-1:0]     r_span;
    logic [CHAN_W-1:0]     r_delta_mag [CHANNELS];
    logic                  r_delta_neg [CHANNELS];
    logic [CHAN_W-1:0]     c_in        [CHANNELS];
    logic [CHAN_W-1:0]     c_out       [CHANNELS];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            c_in[c]  = r_inner_color[COLOR_W-1-CHAN_W*c -: CHAN_W];
            c_out[c] = r_outer_color[COLOR_W-1-CHAN_W*c -: CHAN_W];
        end
    end

    // These are registered and follow the configuration in the next cycle.
    // Users must keep idle time around a configuration write; not enforced here.
    always_ff @(posedge i_clk) begin
        r_inner_sq <= (2*RADIUS_W)'(r_inner) * (2*RADIUS_W)'(r_inner);
        r_outer_sq <= (2*RADIUS_W)'(r_outer) * (2*RADIUS_W)'(r_outer);
        r_span     <= (SPAN_W'(r_outer) - SPAN_W'(r_inner)) << DIST_EXTRA;
        for (int c = 0; c < CHANNELS; c++) begin
            r_delta_neg[c] <= c_out[c] < c_in[c];
            r_delta_mag[c] <= (c_out[c] < c_in[c]) ? c_in[c] - c_out[c]
                                                   : c_out[c] - c_in[c];
        end
    end

    // ------------------------------------------------------------------
    // Front end: offsets, squares, squared distance and radius test
    // ------------------------------------------------------------------
    logic                  accept;
    logic [PXW-1:0]        px;
    logic [PXW-1:0]        py;
    logic signed [DXW-1:0] n_dx;
    logic signed [DXW-1:0] n_dy;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;
    assign px     = i_pixel.pixel_x[PXW-1:0];
    assign py     = i_pixel.pixel_y[PXW-1:0];
    assign n_dx   = $signed({1'b0, MAG_W'(px) << FRAC_BITS}) -
                    $signed({1'b0, MAG_W'(r_center_x)});
    assign n_dy   = $signed({1'b0, MAG_W'(py) << FRAC_BITS}) -
                    $signed({1'b0, MAG_W'(r_center_y)});

    logic                  r_v1, r_v2, r_v3;
    logic signed [DXW-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx3, r_dy3;
    logic [SQ_W-1:0]       r_sqx, r_sqy;
    logic [DSQ_W-1:0]      r_dsq;
    logic                  r_dist_ok3;
    logic [DSQ_W-1:0]      dsq;
    logic [2*DXW-1:0]      sqx_full;
    logic [2*DXW-1:0]      sqy_full;

    assign sqx_full = r_dx1 * r_dx1;
    assign sqy_full = r_dy1 * r_dy1;
    assign dsq      = DSQ_W'(r_sqx) + DSQ_W'(r_sqy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1      <= n_dx;
        r_dy1      <= n_dy;
        r_dx2      <= r_dx1;
        r_dy2      <= r_dy1;
        r_sqx      <= sqx_full[SQ_W-1:0];
        r_sqy      <= sqy_full[SQ_W-1:0];
        r_dx3      <= r_dx2;
        r_dy3      <= r_dy2;
        r_dsq      <= dsq;
        r_dist_ok3 <= (dsq > DSQ_W'(r_inner_sq)) && (dsq < DSQ_W'(r_outer_sq));
    end

    // ------------------------------------------------------------------
    // Distance, then angle
    // ------------------------------------------------------------------
    localparam int SQ_SBW = 1 + 2 * DXW;
    localparam int CO_SBW = 1 + RW;

    logic [2*RW-1:0]   radicand;
    logic              sq_vld;
    logic [RW-1:0]     sq_root;
    logic [SQ_SBW-1:0] sq_side;

    assign radicand = (2*RW)'({r_dsq, {(2*DIST_EXTRA){1'b0}}});

    asgs_isqrt #(
        .RW  (RW),
        .SBW (SQ_SBW)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v3),
        .i_radicand (radicand),
        .i_side     ({r_dist_ok3, r_dx3, r_dy3}),
        .o_valid    (sq_vld),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    logic              co_vld;
    logic [ANG_W-1:0]  co_angle;
    logic [CO_SBW-1:0] co_side;
    logic              co_dist_ok;
    logic [RW-1:0]     co_di;

    asgs_cordic #(
        .DXW    (DXW),
        .STAGES (STG),
        .SBW    (CO_SBW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_dx    ($signed(sq_side[2*DXW-1:DXW])),
        .i_dy    ($signed(sq_side[DXW-1:0])),
        .i_side  ({sq_side[SQ_SBW-1], sq_root}),
        .o_valid (co_vld),
        .o_angle (co_angle),
        .o_side  (co_side)
    );

    assign co_dist_ok = co_side[CO_SBW-1];
    assign co_di      = co_side[RW-1:0];

    // ------------------------------------------------------------------
    // Coverage, distances past each edge, edge factor and numerators
    // ------------------------------------------------------------------
    logic          r_va, r_vb;
    logic          r_cov_a, r_cov_b;
    logic [RW-1:0] r_di1_a, r_di2_a;
    logic [PR_W-1:0]  r_pr_b;
    logic [NUM_W-1:0] r_num_b [CHANNELS];
    logic [PR_W-1:0]  n_pr;

    always_comb begin
        n_pr = PR_W'(ONE_RW);
        if (r_di1_a < ONE_RW) begin
            n_pr = PR_W'(r_di1_a);
        end
        // The outer edge wins when the pixel is near both edges.
        if (r_di2_a < ONE_RW) begin
            n_pr = PR_W'(r_di2_a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= co_vld;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cov_a <= co_dist_ok && (co_angle > ANG_W'(r_start_ang))
                              && (co_angle < ANG_W'(r_end_ang));
        r_di1_a <= co_di - (RW'(r_inner) << DIST_EXTRA);
        r_di2_a <= (RW'(r_outer) << DIST_EXTRA) - co_di;
        r_cov_b <= r_cov_a;
        r_pr_b  <= n_pr;
        for (int c = 0; c < CHANNELS; c++) begin
            r_num_b[c] <= NUM_W'(r_di1_a) * NUM_W'(r_delta_mag[c]);
        end
    end

    // ------------------------------------------------------------------
    // Channel dividers: restoring, one quotient bit per stage
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  r_drem [DIV_STEPS][CHANNELS];
    logic [CHAN_W-1:0] r_dq   [DIV_STEPS][CHANNELS];
    logic              r_dv   [DIV_STEPS];
    logic              r_dcov [DIV_STEPS];
    logic [PR_W-1:0]   r_dpr  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int B = DIV_STEPS - 1 - k;
        logic [NUM_W-1:0]  rem_in [CHANNELS];
        logic [CHAN_W-1:0] q_in   [CHANNELS];
        logic [NUM_W-1:0]  sub;
        logic              v_in;
        logic              cov_in;
        logic [PR_W-1:0]   pr_in;

        assign sub = NUM_W'(r_span) << B;

        if (k == 0) begin : g_first
            always_comb begin
                for (int c = 0; c < CHANNELS; c++) begin
                    rem_in[c] = r_num_b[c];
                    q_in[c]   = '0;
                end
            end
            assign v_in   = r_vb;
            assign cov_in = r_cov_b;
            assign pr_in  = r_pr_b;
        end else begin : g_next
            always_comb begin
                for (int c = 0; c < CHANNELS; c++) begin
                    rem_in[c] = r_drem[k-1][c];
                    q_in[c]   = r_dq[k-1][c];
                end
            end
            assign v_in   = r_dv[k-1];
            assign cov_in = r_dcov[k-1];
            assign pr_in  = r_dpr[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else begin
                r_dv[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dcov[k] <= cov_in;
            r_dpr[k]  <= pr_in;
            for (int c = 0; c < CHANNELS; c++) begin
                if (rem_in[c] >= sub) begin
                    r_drem[k][c] <= rem_in[c] - sub;
                    r_dq[k][c]   <= q_in[c] | (CHAN_W'(1) << B);
                end else begin
                    r_drem[k][c] <= rem_in[c];
                    r_dq[k][c]   <= q_in[c];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Channel values, alpha scaling and the result word
    // ------------------------------------------------------------------
    logic              r_vd;
    logic              r_cov_d;
    logic [CHAN_W-1:0] r_chan_d [CHANNELS];
    logic [AP_W-1:0]   r_aprod_d;
    logic [CHAN_W-1:0] n_chan   [CHANNELS];

    // The quotient magnitude is applied toward the outer color, which
    // truncates the interpolation toward zero.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_chan[c] = r_delta_neg[c] ? c_in[c] - r_dq[DIV_STEPS-1][c]
                                       : c_in[c] + r_dq[DIV_STEPS-1][c];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cov_d   <= r_dcov[DIV_STEPS-1];
        r_aprod_d <= AP_W'(n_chan[CHANNELS-1]) * AP_W'(r_dpr[DIV_STEPS-1]);
        for (int c = 0; c < CHANNELS; c++) begin
            r_chan_d[c] <= n_chan[c];
        end
    end

    t_result r_result;
    logic    r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd     <= 1'b0;
            r_done   <= 1'b0;
            r_result <= '0;
        end else begin
            r_vd   <= r_dv[DIV_STEPS-1];
            r_done <= r_vd;
            if (r_vd && r_cov_d) begin
                r_result.covered <= 1'b1;
                r_result.red     <= r_chan_d[0];
                r_result.green   <= r_chan_d[1];
                r_result.blue    <= r_chan_d[2];
                r_result.alpha   <= CHAN_W'(r_aprod_d >> (FRAC_BITS + DIST_EXTRA));
            end else begin
                r_result <= '0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/core/asgs_checker.sv =====
// ----------------------------------------------------------------------------
// Annular sector gradient shader port checker
// Watches the top-level ports for latency and result-word rules.
// ----------------------------------------------------------------------------
module asgs_checker #(
    parameter int LAT = 57
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input asgs_pkg::t_result o_result
);

    import asgs_pkg::*;

    // Every accepted word produces exactly one result a fixed time later.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted word produced no result");

    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted word");

    a_uncovered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.covered) |-> (o_result == '0))
        else $error("uncovered pixel carries color");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (o_result == '0))
        else $error("result word not cleared between strobes");

endmodule

bind annular_sector_gradient_shader_unit asgs_checker #(
    .LAT (LATENCY)
) u_asgs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== test/annular_sector_gradient_shader_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annular sector gradient shader unit testbench
// Drives pixel words through several register settings, predicts coverage and
// RGBA for each pixel, and compares every result word against the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module annular_sector_gradient_shader_unit_tb;
    import asgs_pkg::*;

    localparam int LATENCY   = 57;
    localparam int LIMIT     = 400000;
    localparam int N_RANDOM  = 850;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_pixel            i_pixel;
    logic              o_done;
    t_result           o_result;
    logic              i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    annular_sector_gradient_shader_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the shader registers.
    logic [15:0] sh_cx, sh_cy, sh_rin, sh_rout;
    logic [14:0] sh_a0, sh_a1;
    logic [31:0] sh_cin, sh_cout;

    t_result pending_pixels[$];
    int      errors;
    longint  cycles;

    typedef struct {
        logic [11:0] px;
        logic [11:0] py;
        bit          known;
        t_result     want;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint tab_atan(int i);
        longint t[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                          262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                          1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        return t[i];
    endfunction

    // CORDIC vectoring angle, 12 fraction bits, about -pi..pi.
    function automatic longint vector_angle(longint x, longint y);
        longint z, xs, ys, mag, q;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            z = (y >= 0) ? 52707179 : -52707179;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + tab_atan(i);
            end else begin
                x = x - ys; y = y + xs; z = z - tab_atan(i);
            end
        end
        mag = (z < 0) ? -z : z;
        q = (mag + 2048) / 4096;
        return (z < 0) ? -q : q;
    endfunction

    function automatic t_result shade_pixel(logic [11:0] px, logic [11:0] py);
        t_result r;
        longint dx, dy, dsq, r1, r2, an, di, di1, di2, span, pr, ab, al;
        longint ch_in, ch_out;
        logic [7:0] ch[4];
        r = '0;
        dx = longint'(px) * 16 - longint'(sh_cx);
        dy = longint'(py) * 16 - longint'(sh_cy);
        dsq = dx * dx + dy * dy;
        r1 = sh_rin;
        r2 = sh_rout;
        if (!(dsq > r1 * r1 && dsq < r2 * r2)) return r;
        an = vector_angle(dx, dy);
        if (an < 0) an = an + 25723;
        if (!(an > longint'(sh_a0) && an < longint'(sh_a1))) return r;
        di = int_sqrt(dsq << 14);
        di1 = di - (r1 << 7);
        di2 = (r2 << 7) - di;
        span = (r2 - r1) << 7;
        pr = 2048;
        if (di1 < 2048) pr = di1;
        if (di2 < 2048) pr = di2;
        for (int k = 0; k < 4; k++) begin
            ch_in = (sh_cin >> (24 - 8 * k)) & 8'hFF;
            ch_out = (sh_cout >> (24 - 8 * k)) & 8'hFF;
            ab = ch_in + (di1 * (ch_out - ch_in)) / span;
            ch[k] = ab[7:0];
            if (k == 3) begin
                al = (ab * pr) / 2048;
                ch[3] = al[7:0];
            end
        end
        r.covered = 1'b1;
        r.red = ch[0]; r.green = ch[1]; r.blue = ch[2]; r.alpha = ch[3];
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_CENTER_X:     sh_cx   = val[15:0];
            CFG_CENTER_Y:     sh_cy   = val[15:0];
            CFG_INNER_RADIUS: sh_rin  = val[15:0];
            CFG_OUTER_RADIUS: sh_rout = val[15:0];
            CFG_START_ANGLE:  sh_a0   = val[14:0];
            CFG_END_ANGLE:    sh_a1   = val[14:0];
            CFG_INNER_COLOR:  sh_cin  = val;
            CFG_OUTER_COLOR:  sh_cout = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 2);
        repeat (n) @(negedge i_clk);
    endtask

    // Holds start until the word is taken; start stays high across back-to-back words.
    task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit known, t_result want,
                              bit gaps);
        t_result w;
        w = known ? want : shade_pixel(px, py);
        if (gaps && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            idle_gap();
        end
        start   <= 1'b1;
        i_pixel <= '{pixel_x: px, pixel_y: py};
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back(w);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic random_setting(int mode);
        logic [15:0] a, b;
        write_reg(CFG_CENTER_X, $urandom_range(0, 65535));
        write_reg(CFG_CENTER_Y, $urandom_range(0, 65535));
        if (mode == 0) begin
            a = $urandom_range(0, 65535); b = $urandom_range(0, 65535);
        end else begin
            a = $urandom_range(0, 2000); b = a + $urandom_range(1, 4000);
        end
        write_reg(CFG_INNER_RADIUS, a);
        write_reg(CFG_OUTER_RADIUS, b);
        a = $urandom_range(0, 32767); b = $urandom_range(0, 32767);
        if (mode != 0 && a > b) begin
            write_reg(CFG_START_ANGLE, b); write_reg(CFG_END_ANGLE, a);
        end else begin
            write_reg(CFG_START_ANGLE, a); write_reg(CFG_END_ANGLE, b);
        end
        write_reg(CFG_INNER_COLOR, $urandom());
        write_reg(CFG_OUTER_COLOR, $urandom());
    endtask

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_done) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected word %h", $time, o_result);
                errors++;
            end else begin
                w = pending_pixels.pop_front();
                if (w.covered !== o_result.covered)
                    $display("%0t: covered exp %h got %h", $time, w.covered, o_result.covered);
                if (w.red !== o_result.red)
                    $display("%0t: red exp %h got %h", $time, w.red, o_result.red);
                if (w.green !== o_result.green)
                    $display("%0t: green exp %h got %h", $time, w.green, o_result.green);
                if (w.blue !== o_result.blue)
                    $display("%0t: blue exp %h got %h", $time, w.blue, o_result.blue);
                if (w.alpha !== o_result.alpha)
                    $display("%0t: alpha exp %h got %h", $time, w.alpha, o_result.alpha);
                if (w !== o_result) errors++;
            end
        end
    end

    initial begin
        t_row rows[$];
        t_result zero;
        int n;
        zero = '0;
        errors = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_pixel = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        sh_cx = 0; sh_cy = 0; sh_rin = 0; sh_rout = OUTER_RADIUS_RST;
        sh_a0 = 0; sh_a1 = WRAP_ANGLE; sh_cin = 0; sh_cout = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values: the origin pixel is the zero vector, far pixels are outside.
        rows.push_back('{12'd0, 12'd0, 1'b1, zero});
        rows.push_back('{12'd4095, 12'd4095, 1'b1, zero});
        rows.push_back('{12'd0, 12'd4095, 1'b1, zero});
        rows.push_back('{12'd4095, 12'd0, 1'b1, zero});
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].want, 0);
        drain();

        // A wide ring around the middle, full circle, distinct colors.
        write_reg(CFG_CENTER_X, 16'd32768);
        write_reg(CFG_CENTER_Y, 16'd32768);
        write_reg(CFG_INNER_RADIUS, 16'd32);
        write_reg(CFG_OUTER_RADIUS, 16'd160);
        write_reg(CFG_START_ANGLE, 15'd0);
        write_reg(CFG_END_ANGLE, 15'd32767);
        write_reg(CFG_INNER_COLOR, 32'h10FF80C0);
        write_reg(CFG_OUTER_COLOR, 32'hF0002040);
        write_reg(CFG_OUTER_COLOR, 32'hF0002040);
        rows.delete();
        rows.push_back('{12'd2048, 12'd2048, 1'b1, zero});  // center
        rows.push_back('{12'd2050, 12'd2048, 1'b0, zero});  // exactly on inner radius
        rows.push_back('{12'd2057, 12'd2048, 1'b0, zero});  // near outer edge
        rows.push_back('{12'd2053, 12'd2048, 1'b0, zero});  // positive x axis
        rows.push_back('{12'd2043, 12'd2048, 1'b0, zero});  // negative x axis
        rows.push_back('{12'd2048, 12'd2053, 1'b0, zero});
        rows.push_back('{12'd2048, 12'd2043, 1'b0, zero});  // negative angle wraps
        rows.push_back('{12'd2044, 12'd2044, 1'b0, zero});
        rows.push_back('{12'd2052, 12'd2044, 1'b0, zero});
        rows.push_back('{12'd2048, 12'd2058, 1'b0, zero});  // exactly on outer radius
        rows.push_back('{12'd2050, 12'd2048, 1'b0, zero});
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].py, rows[i].known, rows[i].want, 0);
        drain();

        // Inner not below outer covers nothing.
        write_reg(CFG_INNER_RADIUS, 16'hFFFF);
        write_reg(CFG_OUTER_RADIUS, 16'hFFFF);
        send_pixel(12'd2053, 12'd2048, 1'b1, zero, 0);
        send_pixel(12'd0, 12'd0, 1'b1, zero, 0);
        drain();

        n = 0;
        while (n < N_RANDOM) begin
            random_setting(($urandom_range(0, 4) == 0) ? 0 : 1);
            repeat ($urandom_range(20, 80)) begin
                logic [11:0] px, py;
                if ($urandom_range(0, 5) == 0) begin
                    px = $urandom_range(0, 4095); py = $urandom_range(0, 4095);
                end else begin
                    px = (sh_cx >> 4) + $urandom_range(0, 500) - 250;
                    py = (sh_cy >> 4) + $urandom_range(0, 500) - 250;
                end
                send_pixel(px, py, 1'b0, zero, 1);
                n++;
            end
            drain();
        end

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== annular_sector_gradient_shader_unit.f =====
rtl/core/asgs_pkg.sv
rtl/core/asgs_isqrt.sv
rtl/core/asgs_cordic.sv
rtl/core/annular_sector_gradient_shader_unit.sv
rtl/core/asgs_checker.sv
test/annular_sector_gradient_shader_unit_tb.sv
